// File: src/hvi_pkg.sv
// Shared types, constants and codes for the Heun sensitivity integrator.
package hvi_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 17;
  localparam int Q30_W  = 30;
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;
  localparam int EXPN_W = 17;
  localparam int FRACU_W = 16;
  localparam int X_W    = 30;
  localparam int W_W    = 31;
  localparam int ACC_W  = 32;
  localparam int K_W    = 3;

  localparam logic [STEP_W-1:0]        STEP_RESET = 17'd655;
  localparam logic signed [WORD_W-1:0] WORD_MAX   = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN   = 32'sh8000_0000;

  // log2(e) and ln(2) in Q30
  localparam logic [OP_W-1:0]  LOG2E_Q30 = 33'd1549082005;
  localparam logic [OP_W-1:0]  LN2_Q30   = 33'd744261118;
  localparam logic [ACC_W-1:0] ONE_Q30   = 32'h4000_0000;

  // ceil(2^33 / k) for the Horner divisors that are not powers of two
  localparam int RECIP_SH = 33;
  localparam logic [ACC_W-1:0] RECIP_3 = 32'd2863311531;
  localparam logic [ACC_W-1:0] RECIP_5 = 32'd1717986919;
  localparam logic [ACC_W-1:0] RECIP_6 = 32'd1431655766;

  localparam logic [K_W-1:0] HORNER_TOP = 3'd6;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } sat_word_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXP_LN,
    ST_EXP_U,
    ST_EXP_F,
    ST_EXP_X,
    ST_H_MUL,
    ST_H_W,
    ST_H_REC,
    ST_H_DIV,
    ST_EXP_SC,
    ST_K1,
    ST_K1_W,
    ST_AP,
    ST_AP_W,
    ST_T1,
    ST_T1_W,
    ST_QT,
    ST_K2,
    ST_K2_W,
    ST_PK,
    ST_APK,
    ST_APK_W,
    ST_T2,
    ST_T2_W,
    ST_HALF,
    ST_UPD,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic start;
    logic load;
    logic last;
    logic out_busy;
  } core_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic emit;
  } core_rsp_t;

endpackage

// File: src/heun_variational_integrator_top.sv
// Top level: Heun sensitivity integrator with stream ports and step size register.
// A step item runs from acceptance through the exp and Heun states to out_tvalid (when
//   marked last); the next item is taken only after it ends, later while a result waits.
// 17 products per step share one 33x33 multiplier, each as an operand and a product state;
//   add and hand-off states make up the rest.
// Reset: synchronous, active low; clears p, q, sat flag, output valid; step size 655.
module heun_variational_integrator_top
  import hvi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input item
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [95:0]         in_tdata,   // start_p[31:0], start_q[63:32], traj_y[95:64]
  input  logic                in_tuser,   // command: 0 load, 1 step
  input  logic                in_tlast,   // last step: emit result after it
  // result item
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,  // end_p[31:0], end_q[63:32]
  output logic                out_tuser,  // saturated
  // step size register
  input  logic                cfg_we,
  input  logic [STEP_W-1:0]   cfg_wdata
);

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  word_t             out_p_r, out_q_r;
  logic              out_sat_r;

  core_req_t req;
  core_rsp_t rsp;
  word_t     core_p, core_q;
  logic      core_sat;

  // Ready only while the sequencer sits idle; a pending result in the output
  // register does not block acceptance, only the final commit of the next one.
  assign in_tready    = rsp.idle;
  assign req.start    = in_tvalid && in_tready;
  assign req.load     = cmd_t'(in_tuser) == CMD_LOAD;
  assign req.last     = in_tlast;
  assign req.out_busy = out_valid_r && !out_tready;

  hvi_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .start_p   (in_tdata[31:0]),
    .start_q   (in_tdata[63:32]),
    .traj_y    (in_tdata[95:64]),
    .step_size (step_r),
    .rsp       (rsp),
    .p_out     (core_p),
    .q_out     (core_q),
    .sat_out   (core_sat)
  );

  // control: step size register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      if (rsp.done && rsp.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, captured when the last step of a run completes
  always_ff @(posedge clk) begin
    if (rsp.done && rsp.emit) begin
      out_p_r   <= core_p;
      out_q_r   <= core_q;
      out_sat_r <= core_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_q_r, out_p_r};
  assign out_tuser  = out_sat_r;

`ifndef SYNTHESIS
  // a step item keeps the sequencer busy on the following cycle
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && cmd_t'(in_tuser) == CMD_STEP |=> !in_tready)
    else $error("input ready while a step is in progress");

  // a result is never committed over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done && rsp.emit |-> !(out_valid_r && !out_tready))
    else $error("result committed over a pending item");

  // a load item never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && cmd_t'(in_tuser) == CMD_LOAD && !out_valid_r
    |=> !out_valid_r)
    else $error("result raised after a load item");
`endif

endmodule

// File: src/hvi_mul.sv
// Shared signed 33x33 multiplier with registered product.
module hvi_mul
  import hvi_pkg::*;
(
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   op_a,
  input  logic signed [OP_W-1:0]   op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// File: src/hvi_exp_scale.sv
// Scales the Q30 mantissa of 2^f by 2^n into Q16.16, saturating on overflow.
module hvi_exp_scale
  import hvi_pkg::*;
(
  input  logic [ACC_W-1:0]         acc,
  input  logic signed [EXPN_W-1:0] n,
  output sat_word_t                res
);

  logic signed [EXPN_W:0] sh;
  logic signed [EXPN_W:0] rsh;
  logic [2*ACC_W-1:0]     up;
  logic [ACC_W-1:0]       dn;

  always_comb begin
    sh  = {n[EXPN_W-1], n} - (EXPN_W+1)'(Q30_W - FRAC_W);
    rsh = -sh;
    up  = {{ACC_W{1'b0}}, acc} << sh[4:0];
    dn  = acc >> rsh[4:0];
    res.sat = 1'b0;
    res.val = '0;
    if (!sh[EXPN_W]) begin
      if (sh > (EXPN_W+1)'(WORD_W - 1) || up[2*ACC_W-1:WORD_W-1] != '0) begin
        res.sat = 1'b1;
        res.val = WORD_MAX;
      end else begin
        res.val = {1'b0, up[WORD_W-2:0]};
      end
    end else if (rsh <= (EXPN_W+1)'(WORD_W - 1)) begin
      res.val = dn;
    end
  end

endmodule

// File: src/hvi_core.sv
// Sequencer and datapath: exp evaluation and one Heun step on the shared multiplier.
module hvi_core
  import hvi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  core_req_t         req,
  input  word_t             start_p,
  input  word_t             start_q,
  input  word_t             traj_y,
  input  logic [STEP_W-1:0] step_size,
  output core_rsp_t         rsp,
  output word_t             p_out,
  output word_t             q_out,
  output logic              sat_out
);

  function automatic sat_word_t sat_add(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    sat_word_t r;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    r.sat = s[WORD_W] != s[WORD_W-1];
    if (r.sat) begin
      r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r.val = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic word_t half_sum(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    return s[WORD_W:1];
  endfunction

  // floor(prod / 2^FRAC_W), clamped to the word range
  function automatic sat_word_t fix_mul(logic signed [PROD_W-1:0] pr);
    logic hi_same;
    sat_word_t r;
    hi_same = (pr[PROD_W-1:FRAC_W+WORD_W-1] == '0) ||
              (pr[PROD_W-1:FRAC_W+WORD_W-1] == '1);
    r.sat = !hi_same;
    if (!hi_same) begin
      r.val = pr[PROD_W-1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.val = pr[FRAC_W+WORD_W-1:FRAC_W];
    end
    return r;
  endfunction

  st_t st_r, st_nxt;
  word_t p_r, p_nxt, q_r, q_nxt;
  word_t a_r, a_nxt, k1_r, k1_nxt, t1_r, t1_nxt, k2_r, k2_nxt, tmp_r, tmp_nxt;
  word_t y_r, y_nxt;
  logic sat_r, sat_nxt, last_r, last_nxt;
  logic signed [EXPN_W-1:0] n_r, n_nxt;
  logic [FRACU_W-1:0] f_r, f_nxt;
  logic [X_W-1:0]     x_r, x_nxt;
  logic [W_W-1:0]     w_r, w_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [K_W-1:0]     k_r, k_nxt;

  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;
  sat_word_t mq, exp_res, add_a, add_b;
  logic [W_W-1:0] w_cur;
  logic [ACC_W-1:0] recip;

  hvi_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  hvi_exp_scale u_exp_scale (
    .acc (acc_r),
    .n   (n_r),
    .res (exp_res)
  );

  assign mq    = fix_mul(prod_r);
  assign w_cur = prod_r[W_W+Q30_W-1:Q30_W];

  always_comb begin
    unique case (k_r)
      3'd3:    recip = RECIP_3;
      3'd5:    recip = RECIP_5;
      default: recip = RECIP_6;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      p_r   <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    k1_r   <= k1_nxt;
    t1_r   <= t1_nxt;
    k2_r   <= k2_nxt;
    tmp_r  <= tmp_nxt;
    y_r    <= y_nxt;
    last_r <= last_nxt;
    n_r    <= n_nxt;
    f_r    <= f_nxt;
    x_r    <= x_nxt;
    w_r    <= w_nxt;
    acc_r  <= acc_nxt;
    k_r    <= k_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    p_nxt    = p_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    a_nxt    = a_r;
    k1_nxt   = k1_r;
    t1_nxt   = t1_r;
    k2_nxt   = k2_r;
    tmp_nxt  = tmp_r;
    y_nxt    = y_r;
    last_nxt = last_r;
    n_nxt    = n_r;
    f_nxt    = f_r;
    x_nxt    = x_r;
    w_nxt    = w_r;
    acc_nxt  = acc_r;
    k_nxt    = k_r;
    op_a     = '0;
    op_b     = '0;
    rsp      = '0;
    add_a    = sat_add(q_r, t1_r);
    add_b    = sat_add(p_r, k1_r);
    unique case (st_r)
      ST_IDLE: begin
        rsp.idle = 1'b1;
        if (req.start) begin
          if (req.load) begin
            p_nxt   = start_p;
            q_nxt   = start_q;
            sat_nxt = 1'b0;
          end else begin
            y_nxt    = traj_y;
            last_nxt = req.last;
            st_nxt   = ST_EXP_LN;
          end
        end
      end
      ST_EXP_LN: begin
        op_a   = -{y_r[WORD_W-1], y_r};
        op_b   = LOG2E_Q30;
        st_nxt = ST_EXP_U;
      end
      ST_EXP_U: begin
        n_nxt  = prod_r[Q30_W+FRAC_W+EXPN_W-1:Q30_W+FRAC_W];
        f_nxt  = prod_r[Q30_W+FRACU_W-1:Q30_W];
        st_nxt = ST_EXP_F;
      end
      ST_EXP_F: begin
        op_a   = {3'b000, f_r, {(Q30_W-FRAC_W){1'b0}}};
        op_b   = LN2_Q30;
        st_nxt = ST_EXP_X;
      end
      ST_EXP_X: begin
        x_nxt   = prod_r[X_W+Q30_W-1:Q30_W];
        acc_nxt = ONE_Q30;
        k_nxt   = HORNER_TOP;
        st_nxt  = ST_H_MUL;
      end
      ST_H_MUL: begin
        op_a   = {3'b000, x_r};
        op_b   = {1'b0, acc_r};
        st_nxt = ST_H_W;
      end
      ST_H_W: begin
        w_nxt = w_cur;
        unique case (k_r)
          3'd3, 3'd5, 3'd6: st_nxt = ST_H_REC;
          3'd4: begin
            acc_nxt = ONE_Q30 + {3'b000, w_cur[W_W-1:2]};
            k_nxt   = k_r - 1'b1;
            st_nxt  = ST_H_MUL;
          end
          3'd2: begin
            acc_nxt = ONE_Q30 + {2'b00, w_cur[W_W-1:1]};
            k_nxt   = k_r - 1'b1;
            st_nxt  = ST_H_MUL;
          end
          default: begin
            acc_nxt = ONE_Q30 + {1'b0, w_cur};
            st_nxt  = ST_EXP_SC;
          end
        endcase
      end
      ST_H_REC: begin
        op_a   = {2'b00, w_r};
        op_b   = {1'b0, recip};
        st_nxt = ST_H_DIV;
      end
      ST_H_DIV: begin
        acc_nxt = ONE_Q30 + {2'b00, prod_r[RECIP_SH+X_W-1:RECIP_SH]};
        k_nxt   = k_r - 1'b1;
        st_nxt  = ST_H_MUL;
      end
      ST_EXP_SC: begin
        a_nxt   = -exp_res.val;
        sat_nxt = sat_r | exp_res.sat;
        st_nxt  = ST_K1;
      end
      ST_K1: begin
        op_a   = {{(OP_W-STEP_W){1'b0}}, step_size};
        op_b   = {q_r[WORD_W-1], q_r};
        st_nxt = ST_K1_W;
      end
      ST_K1_W: begin
        k1_nxt  = mq.val;
        sat_nxt = sat_r | mq.sat;
        st_nxt  = ST_AP;
      end
      ST_AP: begin
        op_a   = {a_r[WORD_W-1], a_r};
        op_b   = {p_r[WORD_W-1], p_r};
        st_nxt = ST_AP_W;
      end
      ST_AP_W: begin
        tmp_nxt = mq.val;
        sat_nxt = sat_r | mq.sat;
        st_nxt  = ST_T1;
      end
      ST_T1: begin
        op_a   = {{(OP_W-STEP_W){1'b0}}, step_size};
        op_b   = {tmp_r[WORD_W-1], tmp_r};
        st_nxt = ST_T1_W;
      end
      ST_T1_W: begin
        t1_nxt  = mq.val;
        sat_nxt = sat_r | mq.sat;
        st_nxt  = ST_QT;
      end
      ST_QT: begin
        tmp_nxt = add_a.val;
        sat_nxt = sat_r | add_a.sat;
        st_nxt  = ST_K2;
      end
      ST_K2: begin
        op_a   = {{(OP_W-STEP_W){1'b0}}, step_size};
        op_b   = {tmp_r[WORD_W-1], tmp_r};
        st_nxt = ST_K2_W;
      end
      ST_K2_W: begin
        k2_nxt  = mq.val;
        sat_nxt = sat_r | mq.sat;
        st_nxt  = ST_PK;
      end
      ST_PK: begin
        tmp_nxt = add_b.val;
        sat_nxt = sat_r | add_b.sat;
        st_nxt  = ST_APK;
      end
      ST_APK: begin
        op_a   = {a_r[WORD_W-1], a_r};
        op_b   = {tmp_r[WORD_W-1], tmp_r};
        st_nxt = ST_APK_W;
      end
      ST_APK_W: begin
        tmp_nxt = mq.val;
        sat_nxt = sat_r | mq.sat;
        st_nxt  = ST_T2;
      end
      ST_T2: begin
        op_a   = {{(OP_W-STEP_W){1'b0}}, step_size};
        op_b   = {tmp_r[WORD_W-1], tmp_r};
        st_nxt = ST_T2_W;
      end
      ST_T2_W: begin
        tmp_nxt = mq.val;
        sat_nxt = sat_r | mq.sat;
        st_nxt  = ST_HALF;
      end
      ST_HALF: begin
        // k1/t1 now carry the half-sums of the two slopes
        k1_nxt = half_sum(k1_r, k2_r);
        t1_nxt = half_sum(t1_r, tmp_r);
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        p_nxt   = add_b.val;
        q_nxt   = add_a.val;
        sat_nxt = sat_r | add_a.sat | add_b.sat;
        st_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (!(last_r && req.out_busy)) begin
          rsp.done = 1'b1;
          rsp.emit = last_r;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign p_out   = p_r;
  assign q_out   = q_r;
  assign sat_out = sat_r;

endmodule

// File: test/tb_heun_variational_integrator_top.sv
// Self-checking testbench for the Heun sensitivity integrator: directed table, then random runs.
`timescale 1ns / 1ps

module tb_heun_variational_integrator_top
  import hvi_pkg::*;
();

  // Q16.16 word limits as 64-bit values for the predictor
  localparam longint W_HI = 2147483647;
  localparam longint W_LO = -W_HI - 1;
  // exp constants in Q30
  localparam longint ONE_FX   = 64'sd1073741824;
  localparam longint LOG2E_FX = 64'sd1549082005;
  localparam longint LN2_FX   = 64'sd744261118;
  // margin of more than one step; leave it before a register write or the end
  localparam int SETTLE_CYCLES = 60;
  // long receiver hold-off, well beyond several steps, so the block backs up
  localparam int LONG_HOLD = 600;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int N_DIRECTED = 20;

  typedef struct packed {
    word_t p;
    word_t q;
    logic  sat;
  } sens_result_t;

  // one input item, with an optional hand-typed expectation
  typedef struct packed {
    cmd_t         cmd;
    word_t        p0;
    word_t        q0;
    word_t        y;
    logic         last;
    logic         typed;
    sens_result_t want;
  } drive_row_t;

  localparam sens_result_t NO_RES = '0;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [95:0]       in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_we     = 1'b0;
  logic [STEP_W-1:0] cfg_wdata  = '0;

  heun_variational_integrator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: step size, p, q and the sticky saturation flag
  longint track_h   = 655;
  longint track_p   = 0;
  longint track_q   = 0;
  bit     track_sat = 1'b0;

  sens_result_t expected_sens[$];
  int           err_count = 0;

  // idling controls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_epoch     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  drive_row_t directed_rows [N_DIRECTED];

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // product, floor-shifted by the fraction width, saturated to the word
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] prod;
    prod = (128'(a) * 128'(b)) >>> FRAC_W;
    if (prod > 128'(W_HI)) begin
      track_sat = 1'b1;
      return W_HI;
    end
    if (prod < 128'(W_LO)) begin
      track_sat = 1'b1;
      return W_LO;
    end
    return prod[63:0];
  endfunction

  function automatic longint fx_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > W_HI) begin
      track_sat = 1'b1;
      return W_HI;
    end
    if (s < W_LO) begin
      track_sat = 1'b1;
      return W_LO;
    end
    return s;
  endfunction

  // floor((a+b)/2), never saturates
  function automatic longint fx_half(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  // exp(-y) via 2^n * 2^f, f by a degree-6 Horner series in Q30
  function automatic longint neg_exp(longint y);
    longint z, u, n, f30, x, acc, s, v;
    z   = -y;
    u   = (z * LOG2E_FX) >>> 30;
    n   = u >>> FRAC_W;
    f30 = (u & 65535) << 14;
    x   = (f30 * LN2_FX) >>> 30;
    acc = ONE_FX;
    for (int k = 6; k >= 1; k--)
      acc = ONE_FX + ((x * acc) >>> 30) / longint'(k);
    s = n + longint'(FRAC_W - 30);
    if (s >= 32) begin
      track_sat = 1'b1;
      return W_HI;
    end
    if (s >= 0) begin
      v = acc << s;
      if (v > W_HI) begin
        track_sat = 1'b1;
        return W_HI;
      end
      return v;
    end
    if (-s >= 63)
      return 0;
    return acc >>> (-s);
  endfunction

  // advance the predictor by one item; returns 1 when a result is due
  function automatic bit integrate_item(input drive_row_t row, output sens_result_t res);
    longint a, k1, t1, k2, t2;
    res = NO_RES;
    if (row.cmd == CMD_LOAD) begin
      track_sat = 1'b0;
      track_p   = longint'(row.p0);
      track_q   = longint'(row.q0);
      return 1'b0;
    end
    a  = -neg_exp(longint'(row.y));
    k1 = fx_mul(track_h, track_q);
    t1 = fx_mul(track_h, fx_mul(a, track_p));
    k2 = fx_mul(track_h, fx_add(track_q, t1));
    t2 = fx_mul(track_h, fx_mul(a, fx_add(track_p, k1)));
    track_p = fx_add(track_p, fx_half(k1, k2));
    track_q = fx_add(track_q, fx_half(t1, t2));
    if (!row.last)
      return 1'b0;
    res.p   = word_t'(track_p);
    res.q   = word_t'(track_q);
    res.sat = track_sat;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random field values
  // ---------------------------------------------------------------------------

  // starting p/q: mostly moderate, some full-range and extremes
  function automatic word_t pick_state();
    case ($urandom_range(9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2, 3, 4: return word_t'($urandom);
      default: return word_t'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  // trajectory sample: mostly within +-4.0 so a stays meaningful
  function automatic word_t pick_traj();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return word_t'($urandom);
      default: return word_t'(int'($urandom_range(0, 524288)) - 262144);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // offer one item, wait for the handshake, then book its expectation
  task automatic send_item(input drive_row_t row);
    sens_result_t res;
    bit           emits;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row.y, row.q0, row.p0};
    in_tuser  <= row.cmd;
    in_tlast  <= row.last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    emits = integrate_item(row, res);
    if (emits)
      expected_sens.push_back(row.typed ? row.want : res);
  endtask

  // drop valid, drain every outstanding result, then let the core finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_sens.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step_size(input logic [STEP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    track_h   = longint'(value);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_seen  <= hold_epoch;
    end else if (hold_seen != hold_epoch) begin
      hold_seen  <= hold_epoch;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: oldest expectation first, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    sens_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sens.size() == 0) begin
        $error("unexpected result item: end_p=%0d end_q=%0d saturated=%0b",
               $signed(out_tdata[31:0]), $signed(out_tdata[63:32]), out_tuser);
        err_count++;
      end else begin
        want = expected_sens.pop_front();
        if (out_tdata[31:0] !== want.p) begin
          $error("end_p: expected %0d, got %0d", want.p, $signed(out_tdata[31:0]));
          err_count++;
        end
        if (out_tdata[63:32] !== want.q) begin
          $error("end_q: expected %0d, got %0d", want.q, $signed(out_tdata[63:32]));
          err_count++;
        end
        if (out_tuser !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, out_tuser);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    drive_row_t row;
    int         left;
    int         run_len;

    // directed table; typed expectations only where obvious
    directed_rows = '{
      // fresh from reset: zero state, y = 0 -> zero result, no saturation
      '{CMD_STEP, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
      // most negative y: exp overflows, flag set, state still zero
      '{CMD_STEP, 32'sd0, 32'sd0, WORD_MIN, 1'b1, 1'b1, '{32'sd0, 32'sd0, 1'b1}},
      // load with last set: last ignored, flag cleared
      '{CMD_LOAD, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0, NO_RES},
      // most positive y: exp underflows to zero
      '{CMD_STEP, 32'sd0, 32'sd0, WORD_MAX, 1'b1, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
      '{CMD_LOAD, WORD_MAX, WORD_MAX, 32'sd0, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, WORD_MIN, 1'b1, 1'b0, NO_RES},
      '{CMD_LOAD, WORD_MIN, WORD_MIN, 32'sd0, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0, NO_RES},
      '{CMD_LOAD, 32'sd65536, 32'sd0, 32'sd0, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, 32'sd65536, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, -32'sd65536, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, 32'sd1, 1'b1, 1'b0, NO_RES},
      // carries on from the emitted state
      '{CMD_STEP, 32'sd0, 32'sd0, -32'sd1, 1'b1, 1'b0, NO_RES},
      // unused fields at extremes on both kinds of item
      '{CMD_LOAD, -32'sd1, 32'sd1, WORD_MIN, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, WORD_MAX, WORD_MIN, 32'sd0, 1'b1, 1'b0, NO_RES},
      '{CMD_LOAD, WORD_MAX, WORD_MIN, WORD_MAX, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, -32'sd655360, 1'b1, 1'b0, NO_RES},
      '{CMD_LOAD, 32'sd0, WORD_MAX, 32'sd0, 1'b0, 1'b0, NO_RES},
      '{CMD_STEP, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0, NO_RES}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      // step size: reset value first, then 65536 (1.0) and 1, the reset value again, then random
      case (ph)
        0:       ;
        1:       write_step_size(17'd65536);
        2:       write_step_size(17'd1);
        3:       write_step_size(STEP_RESET);
        default: write_step_size(STEP_W'($urandom_range(1, 65536)));
      endcase

      // idling mode rotates: none, sender idle, receiver stall, both light
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 61; end
        default: begin send_idle_pct = 8; recv_stall_pct <= 8; end
      endcase

      if (ph == 0) begin
        foreach (directed_rows[i])
          send_item(directed_rows[i]);
      end

      // long receiver hold-off while the sender keeps offering
      if (ph % 4 == 2)
        hold_epoch <= hold_epoch + 1;

      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        if ($urandom_range(99) < 80) begin
          // well-formed run: load, then steps with last on the final one
          row       = '0;
          row.cmd   = CMD_LOAD;
          row.p0    = pick_state();
          row.q0    = pick_state();
          row.y     = word_t'($urandom);
          row.last  = 1'($urandom_range(1));
          send_item(row);
          left--;
          run_len = $urandom_range(1, 8);
          for (int s = 0; s < run_len; s++) begin
            row       = '0;
            row.cmd   = CMD_STEP;
            row.p0    = word_t'($urandom);
            row.q0    = word_t'($urandom);
            row.y     = pick_traj();
            row.last  = (s == run_len - 1);
            send_item(row);
            left--;
          end
        end else begin
          // noise: any kind of item, last at random
          row      = '0;
          row.cmd  = $urandom_range(1) ? CMD_STEP : CMD_LOAD;
          row.p0   = word_t'($urandom);
          row.q0   = word_t'($urandom);
          row.y    = pick_traj();
          row.last = 1'($urandom_range(1));
          send_item(row);
          left--;
        end
      end

      settle();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #(64'd10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
src/hvi_pkg.sv
src/hvi_mul.sv
src/hvi_exp_scale.sv
src/hvi_core.sv
src/heun_variational_integrator_top.sv
test/tb_heun_variational_integrator_top.sv
